// ===== design/pse_pkg.sv =====
package pse_pkg;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] TEN      = 8'd10;

  localparam int STACK_DEPTH_DEF = 128;

  // request kinds between front and back
  localparam logic [2:0] K_PUSH  = 3'd0;
  localparam logic [2:0] K_DIGIT = 3'd1;
  localparam logic [2:0] K_OPEN  = 3'd2;
  localparam logic [2:0] K_CLOSE = 3'd3;
  localparam logic [2:0] K_OP    = 3'd4;
  localparam logic [2:0] K_LEAD  = 3'd5;

  // operator codes, carried in the low bits of arg
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_LEAD  = 3'd1;
  localparam logic [2:0] ERR_DIV0  = 3'd2;
  localparam logic [2:0] ERR_UNDER = 3'd3;
  localparam logic [2:0] ERR_OVER  = 3'd4;
  localparam logic [2:0] ERR_OPEN  = 3'd5;

  localparam int Q_DEPTH = 2;
  localparam int QAW     = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] arg;      // digit value or operator code
    logic       last;
    logic       open_br;  // bracket still open after this request
  } entry_t;

endpackage

// ===== design/pse_ram.sv =====
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pse_front.sv =====
module pse_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  input  logic            q_full,
  output logic            enq,
  output pse_pkg::entry_t enq_item
);
  import pse_pkg::*;

  logic [1:0] pos;
  logic       pos_lead;
  logic [1:0] pos_next;
  logic       in_br;
  logic       in_br_next;
  logic       is_op;
  logic [1:0] op_code;
  logic [7:0] digit;

  assign s_tready = !q_full;
  assign enq      = s_tvalid && !q_full;
  assign digit    = s_tdata - CH_ZERO;
  assign pos_lead = (pos != 2'd2);

  always_comb begin
    is_op   = 1'b1;
    op_code = OP_ADD;
    case (s_tdata)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_STAR:  op_code = OP_MUL;
      CH_SLASH: op_code = OP_DIV;
      default:  is_op = 1'b0;
    endcase
  end

  always_comb begin
    in_br_next       = in_br;
    enq_item.kind    = K_PUSH;
    enq_item.arg     = digit;
    if (pos_lead && is_op) begin
      enq_item.kind = K_LEAD;
    end else if (in_br) begin
      if (s_tdata == CH_CLOSE) begin
        enq_item.kind = K_CLOSE;
        in_br_next    = 1'b0;
      end else begin
        enq_item.kind = K_DIGIT;
      end
    end else if (is_op) begin
      enq_item.kind = K_OP;
      enq_item.arg  = {6'd0, op_code};
    end else if (s_tdata == CH_OPEN) begin
      enq_item.kind = K_OPEN;
      in_br_next    = 1'b1;
    end
    enq_item.last    = s_tlast;
    enq_item.open_br = in_br_next;
    pos_next         = pos_lead ? pos + 2'd1 : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 2'd0;
      in_br <= 1'b0;
    end else if (enq) begin
      if (s_tlast) begin
        pos   <= 2'd0;
        in_br <= 1'b0;
      end else begin
        pos   <= pos_next;
        in_br <= in_br_next;
      end
    end
  end

endmodule

// ===== design/pse_queue.sv =====
module pse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            enq,
  input  pse_pkg::entry_t enq_item,
  output logic            full,
  input  logic            deq,
  output logic            head_valid,
  output pse_pkg::entry_t head
);
  import pse_pkg::*;

  entry_t         slots [Q_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   fill;

  assign full       = (fill == (QAW+1)'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wptr] <= enq_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (enq) begin
        wptr <= (wptr == QAW'(Q_DEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (deq) begin
        rptr <= (rptr == QAW'(Q_DEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      case ({enq, deq})
        2'b10:   fill <= fill + (QAW+1)'(1);
        2'b01:   fill <= fill - (QAW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/pse_div.sv =====
module pse_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);

  logic       busy;
  logic [2:0] step;
  logic [7:0] rem;
  logic [7:0] quo;
  logic [7:0] dvs;
  logic       neg;
  logic [8:0] shifted;
  logic       fits;

  // one restoring step per cycle on magnitudes
  assign shifted  = {rem, quo[7]};
  assign fits     = (shifted >= {1'b0, dvs});
  assign quotient = neg ? (8'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 8'd0;
      quo <= dividend[7] ? (8'd0 - dividend) : dividend;
      dvs <= divisor[7] ? (8'd0 - divisor) : divisor;
      neg <= dividend[7] ^ divisor[7];
    end else if (busy) begin
      rem <= fits ? 8'(shifted - {1'b0, dvs}) : shifted[7:0];
      quo <= {quo[6:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 3'd7);
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/pse_back.sv =====
module pse_back #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  pse_pkg::entry_t q_item,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata
);
  import pse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [7:0]    top;
  logic [7:0]    top_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [7:0]    bval;
  logic [7:0]    bval_next;
  logic [2:0]    err;
  logic [2:0]    err_next;
  logic [1:0]    cur_op;
  logic          cur_last;
  logic          cur_open;
  logic          out_valid;
  logic [7:0]    out_value;
  logic [2:0]    out_err;

  logic          fin;
  logic          fin_last;
  logic          fin_open;
  logic [2:0]    fin_err;
  logic          do_push;
  logic [7:0]    push_val;
  logic          take;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [15:0]   prod;
  logic          div_start;
  logic          div_done;
  logic [7:0]    div_q;

  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign prod     = ram_rdata * top;
  assign take     = q_valid && (!q_item.last || !out_valid);
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_err, out_value};

  always_comb begin
    state_next = state;
    top_next   = top;
    count_next = count;
    bval_next  = bval;
    err_next   = err;
    q_pop      = 1'b0;
    fin        = 1'b0;
    fin_last   = cur_last;
    fin_open   = cur_open;
    do_push    = 1'b0;
    push_val   = q_item.arg;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        fin_last = q_item.last;
        fin_open = q_item.open_br;
        if (take) begin
          q_pop = 1'b1;
          fin   = 1'b1;
          if (err == ERR_NONE) begin
            case (q_item.kind)
              K_LEAD:  err_next = ERR_LEAD;
              K_PUSH:  do_push = 1'b1;
              K_DIGIT: bval_next = 8'(bval * TEN) + q_item.arg;
              K_OPEN:  bval_next = 8'd0;
              K_CLOSE: begin
                do_push  = 1'b1;
                push_val = bval;
              end
              K_OP: begin
                if (count < CW'(2)) begin
                  err_next = ERR_UNDER;
                end else begin
                  fin        = 1'b0;
                  state_next = ST_EXEC;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
      ST_EXEC: begin
        case (cur_op)
          OP_ADD: begin
            top_next   = ram_rdata + top;
            count_next = cnt_m1;
            fin        = 1'b1;
          end
          OP_SUB: begin
            top_next   = ram_rdata - top;
            count_next = cnt_m1;
            fin        = 1'b1;
          end
          OP_MUL: begin
            top_next   = prod[7:0];
            count_next = cnt_m1;
            fin        = 1'b1;
          end
          default: begin
            if (top == 8'd0) begin
              err_next = ERR_DIV0;
              fin      = 1'b1;
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          top_next   = div_q;
          count_next = cnt_m1;
          fin        = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (do_push) begin
      if (count >= CW'(STACK_DEPTH)) begin
        err_next = ERR_OVER;
      end else begin
        top_next   = push_val;
        count_next = count + CW'(1);
      end
    end

    fin_err = err_next;
    if (fin_err == ERR_NONE && fin_open) begin
      fin_err = ERR_OPEN;
    end
    if (fin_err == ERR_NONE && count_next == '0) begin
      fin_err = ERR_UNDER;
    end

    if (fin) begin
      state_next = ST_IDLE;
      if (fin_last) begin
        count_next = '0;
        err_next   = ERR_NONE;
        bval_next  = 8'd0;
      end
    end
  end

  // the old top goes down into memory when a new value lands on it
  assign ram_we = do_push && (count != '0) && (count < CW'(STACK_DEPTH));

  pse_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (top),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    top <= top_next;
    if (state == ST_IDLE && take) begin
      cur_op   <= q_item.arg[1:0];
      cur_last <= q_item.last;
      cur_open <= q_item.open_br;
    end
    if (fin && fin_last) begin
      out_value <= (fin_err == ERR_NONE) ? top_next : 8'd0;
      out_err   <= fin_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      bval      <= 8'd0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      bval      <= bval_next;
      err       <= err_next;
      out_valid <= (out_valid && !m_tready) || (fin && fin_last);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (err == ERR_NONE))
    else $error("division running after an error");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop)
    else $error("queue popped while an operator is in flight");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (fin && fin_last) |=> (count == '0 && err == ERR_NONE && out_valid))
    else $error("state not cleared after end of expression");
`endif

endmodule

// ===== design/postfix_stack_evaluator.sv =====
// postfix evaluator on an 8-bit signed stack, one ascii character per input
// request. digits push c-'0', a bracketed run "(ddd)" builds one number
// (value*10+digit, wrapped to 8 bits), and + - * / pop two values, compute,
// wrap and push; division truncates toward zero. the request marked with
// s_tlast ends the expression: one output request carries the top of stack
// and an error code (0 ok, 1 leading operator, 2 divide by zero, 3 underflow,
// 4 overflow, 5 open bracket; value is 0 on any error) and the block clears
// itself. a front stage classifies characters and feeds a two-entry queue;
// the back stage executes. in the back, a push, digit or bracket finishes in
// the idle state; + - * pass through an exec state (registered read of the
// second operand from the stack memory); / with a nonzero divisor then waits
// in a div state on the bit-serial divider that resolves one quotient bit per
// cycle. an operator with too few operands, and after an error any request
// up to the end of the expression, finish in the idle state. the request
// that ends an expression waits in the queue while the previous result is
// still held on the output. no clearing pass after reset.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // end_of_expr
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] value, [10:8] error_code, rest zero
);
  import pse_pkg::*;

  // front to queue
  logic   enq;
  entry_t enq_item;
  logic   q_full;
  // queue to back
  logic   q_valid;
  entry_t q_head;
  logic   q_pop;

  // classifier: tracks position for the leading-operator rule and the
  // bracket state, so the back only sees ready-made requests
  pse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .enq      (enq),
    .enq_item (enq_item)
  );

  // decoupling queue, lets the front keep taking input during a division until it is full
  pse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .enq        (enq),
    .enq_item   (enq_item),
    .full       (q_full),
    .deq        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // executor: stack memory with cached top, arithmetic, sticky error and
  // the output register
  pse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
